FILE: src/llch_pkg.sv
`timescale 1ns / 1ps

package llch_pkg;

   // Width of a load value and of the run time that is added to it.
   localparam int LOAD_W = 32;

   // Width of the reported core number.
   localparam int CORE_ID_W = 3;

   // Register file layout.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int ACTIVE_W = 4;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   // Word index of the active core count register.
   localparam logic [CSR_ADDR_W-3:0] REG_ACTIVE_CORES = 1'b0;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROOT   = 5'b00010,
      ST_CHILD  = 5'b00100,
      ST_PARENT = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

FILE: src/llch_ram.sv
`timescale 1ns / 1ps

module llch_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: src/least_loaded_core_heap_top.sv
`timescale 1ns / 1ps

// Least loaded core scheduler. Each item on the request channel is the run time of one new
// process; the block adds it to the core that currently carries the least load (lower core
// number wins a tie), saturating at 0xFFFFFFFF, and returns that core's number and new load
// on the response channel, one response per request. The cores live in a binary min-heap
// held in a small two-read-port RAM and are re-ordered by a sift-down that reuses a single
// key comparator under a small sequencer. The response is registered in the ROOT state once
// the previous response has been taken; while it still waits, the rest of the item waits too.
// The block is then busy with the sift-down and takes no new request until the moving entry
// settles, which for eight cores walks at most 3 heap levels. Each level reads both children
// from the RAM at once and uses the comparator once in CHILD and once in PARENT. Writing the
// active_cores register (word 0; the user must write it only while idle, the block does not
// enforce this) resets the heap to cores 0..n-1 with zero load at once; no clearing pass is
// needed. A value of zero counts as one core and a value above NUM_CORES counts as NUM_CORES.
module least_loaded_core_heap_top #(
   parameter int NUM_CORES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [llch_pkg::LOAD_W-1:0]          req_run_time,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [llch_pkg::CORE_ID_W-1:0]       rsp_core_id,
   output logic [llch_pkg::LOAD_W-1:0]          rsp_core_load,

   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [llch_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [llch_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [llch_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   import llch_pkg::*;

   // Heap slot addresses and stored core numbers share one width.
   localparam int ADDR_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int LEN_W = $clog2(NUM_CORES + 1);
   // A heap entry is {load, core}; comparing it as one unsigned number gives the
   // load order with the core number breaking ties.
   localparam int KEY_W = LOAD_W + ADDR_W;
   localparam int WIDE_W = (ADDR_W + 2 > LEN_W) ? ADDR_W + 2 : LEN_W;
   localparam int CMP_W = (LEN_W > ACTIVE_W) ? LEN_W : ACTIVE_W;
   localparam int RESET_LEN = (NUM_CORES < int'(ACTIVE_RESET)) ? NUM_CORES
                                                               : int'(ACTIVE_RESET);

   // ------------------------------------------------------------------
   // Configuration register.
   // ------------------------------------------------------------------
   logic [ACTIVE_W-1:0] active_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [LEN_W-1:0]    len_in;
   logic                csr_write;
   logic                csr_hit;
   logic [CMP_W-1:0]    act_ext;

   assign pready = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_ACTIVE_CORES);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata = csr_hit ? CSR_DATA_W'(active_ff) : '0;

   // The heap size is the written count held between one and NUM_CORES.
   always_comb begin
      act_ext = CMP_W'(pwdata[ACTIVE_W-1:0]);
      priority if (act_ext == '0) begin
         len_in = LEN_W'(1);
      end else if (act_ext > CMP_W'(NUM_CORES)) begin
         len_in = LEN_W'(NUM_CORES);
      end else begin
         len_in = act_ext[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         len_ff <= LEN_W'(RESET_LEN);
      end else if (csr_write) begin
         active_ff <= pwdata[ACTIVE_W-1:0];
         len_ff <= len_in;
      end
   end

   // ------------------------------------------------------------------
   // Heap storage. A slot whose valid bit is clear reads as its reset
   // contents: core number equal to the slot index and zero load.
   // ------------------------------------------------------------------
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [KEY_W-1:0]     wr_data;
   logic [ADDR_W-1:0]    rd_addr_a;
   logic [ADDR_W-1:0]    rd_addr_b;
   logic [KEY_W-1:0]     ram_a;
   logic [KEY_W-1:0]     ram_b;
   logic [ADDR_W-1:0]    addr_a_ff;
   logic [ADDR_W-1:0]    addr_b_ff;
   logic                 vld_a_ff;
   logic                 vld_b_ff;
   logic [NUM_CORES-1:0] vld_ff;
   logic [KEY_W-1:0]     ent_a;
   logic [KEY_W-1:0]     ent_b;

   llch_ram #(
      .WIDTH (KEY_W),
      .DEPTH (NUM_CORES)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (ram_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      addr_a_ff <= rd_addr_a;
      addr_b_ff <= rd_addr_b;
      vld_a_ff <= vld_ff[rd_addr_a];
      vld_b_ff <= vld_ff[rd_addr_b];
   end

   assign ent_a = vld_a_ff ? ram_a : {LOAD_W'(0), addr_a_ff};
   assign ent_b = vld_b_ff ? ram_b : {LOAD_W'(0), addr_b_ff};

   // ------------------------------------------------------------------
   // Shared key comparator: true when entry x orders before entry y.
   // ------------------------------------------------------------------
   logic [KEY_W-1:0] cmp_x;
   logic [KEY_W-1:0] cmp_y;
   logic             x_before_y;

   assign x_before_y = (cmp_x < cmp_y);

   // ------------------------------------------------------------------
   // Root update: saturating add of the new run time.
   // ------------------------------------------------------------------
   logic [LOAD_W-1:0] run_time_ff;
   logic [LOAD_W:0]   sum_wide;
   logic [LOAD_W-1:0] sum_sat;
   logic [KEY_W-1:0]  root_new;

   assign sum_wide = {1'b0, ent_a[KEY_W-1:ADDR_W]} + {1'b0, run_time_ff};
   assign sum_sat = sum_wide[LOAD_W] ? '1 : sum_wide[LOAD_W-1:0];
   assign root_new = {sum_sat, ent_a[ADDR_W-1:0]};

   // ------------------------------------------------------------------
   // Children of the slot the sift moves into next. Slot q (from zero)
   // has children 2q+1 and 2q+2; those at or beyond the heap size are
   // absent.
   // ------------------------------------------------------------------
   state_type         state_ff;
   state_type         state_in;
   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;
   logic [KEY_W-1:0]  cur_ff;
   logic [KEY_W-1:0]  cur_in;
   logic [KEY_W-1:0]  child_ff;
   logic [KEY_W-1:0]  child_in;
   logic [ADDR_W-1:0] child_addr_ff;
   logic [ADDR_W-1:0] child_addr_in;
   logic              has_b_ff;
   logic              has_b_in;
   logic [ADDR_W-1:0] desc_pos;
   logic [WIDE_W-1:0] kid_a;
   logic [WIDE_W-1:0] kid_b;
   logic              has_a;
   logic              has_b;
   logic              rsp_load;
   logic              rsp_valid_ff;

   assign desc_pos = (state_ff == ST_PARENT) ? child_addr_ff : '0;
   assign kid_a = (WIDE_W'(desc_pos) << 1) + WIDE_W'(1);
   assign kid_b = kid_a + WIDE_W'(1);
   assign has_a = (kid_a < WIDE_W'(len_ff));
   assign has_b = (kid_b < WIDE_W'(len_ff));

   // ------------------------------------------------------------------
   // Sequencer.
   // IDLE:   take a request; slot zero is being read meanwhile.
   // ROOT:   add the run time to the root, register the response once the
   //         response register is free, and fetch the root's children.
   // CHILD:  pick the smaller of the two children.
   // PARENT: if the moving entry orders before that child it settles here;
   //         otherwise the child moves up and the sift goes one level down.
   // FINISH: the moving entry settles in a leaf.
   // ------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      child_in = child_ff;
      child_addr_in = child_addr_ff;
      has_b_in = has_b_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;
      cmp_x = ent_b;
      cmp_y = ent_a;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // While the previous response still waits, slot zero keeps
            // being read so its data stays in place.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               cur_in = root_new;
               pos_in = '0;
               if (has_a) begin
                  rd_addr_a = kid_a[ADDR_W-1:0];
                  rd_addr_b = kid_b[ADDR_W-1:0];
                  has_b_in = has_b;
                  state_in = ST_CHILD;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = '0;
                  wr_data = root_new;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CHILD: begin
            cmp_x = ent_b;
            cmp_y = ent_a;
            if (has_b_ff && x_before_y) begin
               child_in = ent_b;
               child_addr_in = addr_b_ff;
            end else begin
               child_in = ent_a;
               child_addr_in = addr_a_ff;
            end
            state_in = ST_PARENT;
         end
         ST_PARENT: begin
            cmp_x = cur_ff;
            cmp_y = child_ff;
            wr_en = 1'b1;
            wr_addr = pos_ff;
            if (x_before_y) begin
               wr_data = cur_ff;
               state_in = ST_IDLE;
            end else begin
               wr_data = child_ff;
               pos_in = child_addr_ff;
               if (has_a) begin
                  rd_addr_a = kid_a[ADDR_W-1:0];
                  rd_addr_b = kid_b[ADDR_W-1:0];
                  has_b_in = has_b;
                  state_in = ST_CHILD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            wr_en = 1'b1;
            wr_addr = pos_ff;
            wr_data = cur_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         run_time_ff <= req_run_time;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      child_ff <= child_in;
      child_addr_ff <= child_addr_in;
      has_b_ff <= has_b_in;
   end

   // ------------------------------------------------------------------
   // Response register. The core number is reported in three bits.
   // ------------------------------------------------------------------
   logic [CORE_ID_W-1:0]      rsp_core_id_ff;
   logic [LOAD_W-1:0]         rsp_core_load_ff;
   logic [ADDR_W+CORE_ID_W-1:0] id_ext;

   assign id_ext = (ADDR_W + CORE_ID_W)'(ent_a[ADDR_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_core_id_ff <= id_ext[CORE_ID_W-1:0];
         rsp_core_load_ff <= sum_sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_core_id = rsp_core_id_ff;
   assign rsp_core_load = rsp_core_load_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // A taken request always moves the sequencer to the root update.
   a_accept_to_root : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ROOT))
      else $error("request taken without a root update");

   // A new response only ever comes from the root update.
   a_rsp_from_root : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_ROOT))
      else $error("response raised outside the root update");

   // The heap is only ever written inside its current size.
   a_write_in_heap : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (WIDE_W'(wr_addr) < WIDE_W'(len_ff)))
      else $error("heap write beyond the active cores");

   // The sift always compares against a slot below the current one.
   a_child_below : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PARENT) |-> (child_addr_ff > pos_ff))
      else $error("sift child is not below its parent");

endmodule
